FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RRTD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RRTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/rrtd_pkg.sv
// Shared types and codes for the round-robin task dispatcher.
package rrtd_pkg;

  localparam int FUNC_W = 2;
  localparam int ST_W   = 2;
  localparam int ID_W   = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 2'd0,
    FN_DEL      = 2'd1,
    FN_READY    = 2'd2,
    FN_DISPATCH = 2'd3
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_IDLE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

FILE: rtl/core/round_robin_task_dispatcher.sv
// Round-robin task dispatcher top level: slot table, sequencer and output register.
// Delete, set-ready and immediate errors skip the scanner and reach the output via S_EMIT.
// Add and dispatch scan one slot per cycle in a shared scanner.
// A new beat is taken once the previous result has moved into the output register,
// so beats never overlap, and an output stall also holds off the next beat.
// Synchronous active-low reset empties the table and sets the last served slot to 0.
module round_robin_task_dispatcher #(
  parameter int TASK_SLOTS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rrtd_pkg::FUNC_W-1:0] in_func,
  input  logic [rrtd_pkg::ID_W-1:0]   in_task_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrtd_pkg::ST_W-1:0]   out_status,
  output logic [rrtd_pkg::ID_W-1:0]   out_result_id
);
  import rrtd_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
  localparam logic [ID_W-1:0]  SLOTS_ID = ID_W'(TASK_SLOTS);

  state_t                 state_r, state_nxt;
  logic [TASK_SLOTS-1:0]  occ_r, occ_nxt;
  logic [TASK_SLOTS-1:0]  rdy_r, rdy_nxt;
  logic [IDX_W-1:0]       last_r, last_nxt;
  func_t                  op_r, op_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [ID_W-1:0]        res_id_r, res_id_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [ID_W-1:0]        out_id_r, out_id_nxt;

  func_t                  func_c;
  logic                   id_bad;
  logic [ID_W-1:0]        id_dec;
  logic [IDX_W-1:0]       id_idx;
  logic                   scan_load;
  logic [IDX_W-1:0]       scan_start;
  logic [TASK_SLOTS-1:0]  scan_mask;
  scan_rsp_t              scan_rsp;
  logic [IDX_W-1:0]       scan_idx;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_result_id = out_id_r;

  assign func_c    = func_t'(in_func);
  assign id_bad    = (in_task_id == '0) || (in_task_id > SLOTS_ID);
  assign id_dec    = in_task_id - ID_W'(1);
  assign id_idx    = id_dec[IDX_W-1:0];
  assign scan_mask = (op_r == FN_ADD) ? ~occ_r : rdy_r;

  rrtd_scan #(
    .SLOTS (TASK_SLOTS),
    .IDX_W (IDX_W)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_i  (scan_load),
    .start_i (scan_start),
    .mask_i  (scan_mask),
    .rsp_o   (scan_rsp),
    .idx_o   (scan_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    rdy_nxt        = rdy_r;
    last_nxt       = last_r;
    op_nxt         = op_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    scan_load      = 1'b0;
    scan_start     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (func_c)
            FN_ADD: begin
              if (&occ_r) begin
                res_status_nxt = ST_FULL;
                res_id_nxt     = '0;
                state_nxt      = S_EMIT;
              end else begin
                scan_load  = 1'b1;
                scan_start = '0;
                op_nxt     = FN_ADD;
                state_nxt  = S_SCAN;
              end
            end
            FN_DEL, FN_READY: begin
              res_id_nxt = '0;
              state_nxt  = S_EMIT;
              if (id_bad || !occ_r[id_idx]) begin
                res_status_nxt = ST_BAD;
              end else begin
                res_status_nxt = ST_OK;
                if (func_c == FN_DEL) begin
                  occ_nxt[id_idx] = 1'b0;
                  rdy_nxt[id_idx] = 1'b0;
                end else begin
                  rdy_nxt[id_idx] = 1'b1;
                end
              end
            end
            FN_DISPATCH: begin
              if (rdy_r == '0) begin
                res_status_nxt = ST_IDLE;
                res_id_nxt     = '0;
                state_nxt      = S_EMIT;
              end else begin
                scan_load  = 1'b1;
                scan_start = (last_r == LAST_IDX) ? '0 : last_r + IDX_W'(1);
                op_nxt     = FN_DISPATCH;
                state_nxt  = S_SCAN;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_rsp.done) begin
          state_nxt = S_EMIT;
          if (scan_rsp.hit) begin
            res_status_nxt = ST_OK;
            res_id_nxt     = ID_W'(scan_idx) + ID_W'(1);
            rdy_nxt[scan_idx] = 1'b0;
            if (op_r == FN_ADD) begin
              occ_nxt[scan_idx] = 1'b1;
            end else begin
              last_nxt = scan_idx;
            end
          end else begin
            res_status_nxt = (op_r == FN_ADD) ? ST_FULL : ST_IDLE;
            res_id_nxt     = '0;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      rdy_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rdy_r       <= rdy_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  `RRTD_ASSERT_SAME(a_ready_subset_occ, 1'b1, (rdy_r & ~occ_r) == '0)
  `RRTD_ASSERT_SAME(a_scan_always_hits, state_r == S_SCAN && scan_rsp.done, scan_rsp.hit)
  `RRTD_ASSERT_SAME(a_err_has_zero_id, out_valid_r && out_status_r != ST_OK, out_id_r == '0)
  `RRTD_ASSERT_NEXT(a_scan_busy_after_load, scan_load, scan_rsp.busy && state_r == S_SCAN)

endmodule

FILE: rtl/core/rrtd_scan.sv
// Shared slot scanner that tests one mask bit per cycle with wrap-around.
module rrtd_scan #(
  parameter int SLOTS = 32,
  parameter int IDX_W = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_i,
  input  logic [IDX_W-1:0]     start_i,
  input  logic [SLOTS-1:0]     mask_i,
  output rrtd_pkg::scan_rsp_t  rsp_o,
  output logic [IDX_W-1:0]     idx_o
);
  import rrtd_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cur_bit;
  logic             last_step;

  assign cur_bit   = mask_i[idx_r];
  assign last_step = (cnt_r == CNT_W'(1));

  assign rsp_o.busy = busy_r;
  assign rsp_o.hit  = busy_r && cur_bit;
  assign rsp_o.done = busy_r && (cur_bit || last_step);
  assign idx_o      = idx_r;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    if (load_i) begin
      busy_nxt = 1'b1;
      idx_nxt  = start_i;
      cnt_nxt  = CNT_W'(SLOTS);
    end else if (busy_r) begin
      if (rsp_o.done) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule
